[sv/lcpd_pkg.sv]
// Shared types, codes and the CRC-16 byte update for the packet deframer.
package lcpd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd2048;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CRC_ERR  = 2'd1;
  localparam logic [1:0] ST_SIZE_ERR = 2'd2;

  // classified operations passed from front to back
  localparam logic [2:0] OP_BYTE      = 3'd0;
  localparam logic [2:0] OP_LAST_OK   = 3'd1;
  localparam logic [2:0] OP_LAST_BAD  = 3'd2;
  localparam logic [2:0] OP_EMPTY_OK  = 3'd3;
  localparam logic [2:0] OP_EMPTY_BAD = 3'd4;
  localparam logic [2:0] OP_SIZE_ERR  = 3'd5;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] payload_byte;
    logic       end_of_packet;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
  } q_entry_t;

  // reflected CRC-16, one byte, unrolled over eight bits
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/length_crc_packet_deframer_top.sv]
// Top level of the length-prefixed CRC-16 packet deframer.
//
// Input side is a queue write port: an item (restart flag plus stream byte)
// is taken on a clock edge with push high and full low. Each frame is a
// 16-bit little-endian length, a 16-bit little-endian CRC, then the payload.
// Result side is a queue read port: the oldest result sits on result while
// empty is low and is taken on an edge with pop high.
// Throughput is one beat per cycle in both directions while full is low and
// pop is high; the CRC update for a whole byte is done in the cycle the byte
// is taken. A taken byte goes into the queue, then into the output register.
// A QUEUE_DEPTH-entry queue plus the output register absorb a stalled
// receiver; full rises once they hold QUEUE_DEPTH + 1 results.
// Header beats and halted data beats produce no result, but for the last
// header beat of a frame that is empty or too long. cfg_wr_en / cfg_wr_data
// write the maximum payload length at once. Reset sets the maximum length
// to 2048, clears framing state, empties the queue and the output register.
module length_crc_packet_deframer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [15:0]     cfg_wr_data,
  input  logic            push,
  output logic            full,
  input  lcpd_pkg::in_t   item,
  output logic            empty,
  input  logic            pop,
  output lcpd_pkg::out_t  result
);

  logic               q_push, q_pop, q_full, q_empty;
  lcpd_pkg::q_entry_t q_wr_data, q_rd_data;

  assign full = q_full;

  lcpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .item        (item),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wr_data)
  );

  lcpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  lcpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_rd_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

[sv/lcpd_front.sv]
// Front end: header parsing, length check, running CRC and beat classification.
module lcpd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                push,
  input  lcpd_pkg::in_t       item,
  input  logic                q_full,
  output logic                q_push,
  output lcpd_pkg::q_entry_t  q_data
);

  localparam logic [2:0] PH_LEN_LO  = 3'd0;
  localparam logic [2:0] PH_LEN_HI  = 3'd1;
  localparam logic [2:0] PH_CRC_LO  = 3'd2;
  localparam logic [2:0] PH_CRC_HI  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_HALT    = 3'd5;

  logic [15:0] max_length;
  logic [2:0]  phase, phase_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] expected_crc, expected_crc_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        accept;
  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [15:0] exp_full;

  assign accept   = push && !q_full;
  assign b        = item.data_byte;
  assign crc_upd  = lcpd_pkg::crc16_byte(running_crc, b);
  assign exp_full = {b, expected_crc[7:0]};

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    expected_crc_next = expected_crc;
    running_crc_next  = running_crc;
    bytes_left_next   = bytes_left;
    q_push            = 1'b0;
    q_data.op         = lcpd_pkg::OP_BYTE;
    q_data.data_byte  = b;
    if (accept) begin
      if (item.action) begin
        phase_next        = PH_LEN_LO;
        frame_length_next = '0;
        expected_crc_next = '0;
        running_crc_next  = lcpd_pkg::CRC_INIT;
        bytes_left_next   = '0;
      end else begin
        unique case (phase)
          PH_LEN_LO: begin
            frame_length_next = {8'h00, b};
            phase_next        = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            frame_length_next = {b, frame_length[7:0]};
            phase_next        = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            expected_crc_next = {8'h00, b};
            phase_next        = PH_CRC_HI;
          end
          PH_CRC_HI: begin
            expected_crc_next = exp_full;
            running_crc_next  = lcpd_pkg::CRC_INIT;
            if (frame_length > max_length) begin
              phase_next = PH_HALT;
              q_push     = 1'b1;
              q_data.op  = lcpd_pkg::OP_SIZE_ERR;
            end else if (frame_length == 16'd0) begin
              q_push = 1'b1;
              if (exp_full != lcpd_pkg::CRC_INIT) begin
                phase_next = PH_HALT;
                q_data.op  = lcpd_pkg::OP_EMPTY_BAD;
              end else begin
                phase_next = PH_LEN_LO;
                q_data.op  = lcpd_pkg::OP_EMPTY_OK;
              end
            end else begin
              bytes_left_next = frame_length;
              phase_next      = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            running_crc_next = crc_upd;
            bytes_left_next  = bytes_left - 16'd1;
            q_push           = 1'b1;
            if (bytes_left == 16'd1) begin
              if (crc_upd != expected_crc) begin
                phase_next = PH_HALT;
                q_data.op  = lcpd_pkg::OP_LAST_BAD;
              end else begin
                phase_next = PH_LEN_LO;
                q_data.op  = lcpd_pkg::OP_LAST_OK;
              end
            end
          end
          default: begin
            // halted: drop data beats
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length   <= lcpd_pkg::MAX_LENGTH_RESET;
      phase        <= PH_LEN_LO;
      frame_length <= '0;
      expected_crc <= '0;
      running_crc  <= lcpd_pkg::CRC_INIT;
      bytes_left   <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_length <= cfg_wr_data;
      end
      phase        <= phase_next;
      frame_length <= frame_length_next;
      expected_crc <= expected_crc_next;
      running_crc  <= running_crc_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

[sv/lcpd_queue.sv]
// Short register queue between the front and back ends.
module lcpd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  lcpd_pkg::q_entry_t  wr_data,
  input  logic                rd,
  output lcpd_pkg::q_entry_t  rd_data,
  output logic                full,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  lcpd_pkg::q_entry_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == DEPTH_C);
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> (!full || rd))
    else $error("queue write while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
      (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

[sv/lcpd_back.sv]
// Back end: turns classified beats into result items held in an output register.
module lcpd_back (
  input  logic                clk,
  input  logic                rst,
  input  lcpd_pkg::q_entry_t  q_data,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output lcpd_pkg::out_t      result
);

  logic           out_valid;
  lcpd_pkg::out_t res_next;

  assign q_pop = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    res_next.has_byte      = 1'b0;
    res_next.payload_byte  = 8'h00;
    res_next.end_of_packet = 1'b1;
    res_next.status        = lcpd_pkg::ST_OK;
    unique case (q_data.op)
      lcpd_pkg::OP_BYTE: begin
        res_next.has_byte      = 1'b1;
        res_next.payload_byte  = q_data.data_byte;
        res_next.end_of_packet = 1'b0;
      end
      lcpd_pkg::OP_LAST_OK: begin
        res_next.has_byte     = 1'b1;
        res_next.payload_byte = q_data.data_byte;
      end
      lcpd_pkg::OP_LAST_BAD: begin
        res_next.has_byte     = 1'b1;
        res_next.payload_byte = q_data.data_byte;
        res_next.status       = lcpd_pkg::ST_CRC_ERR;
      end
      lcpd_pkg::OP_EMPTY_OK: begin
        res_next.status = lcpd_pkg::ST_OK;
      end
      lcpd_pkg::OP_EMPTY_BAD: begin
        res_next.status = lcpd_pkg::ST_CRC_ERR;
      end
      lcpd_pkg::OP_SIZE_ERR: begin
        res_next.status = lcpd_pkg::ST_SIZE_ERR;
      end
      default: begin
        res_next.status = lcpd_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= res_next;
    end
  end

endmodule

[test/tb.sv]
// Testbench for length_crc_packet_deframer_top: frame traffic, predictor and scoreboard.
`timescale 1ns / 100ps

typedef logic [7:0] byte_q_t[$];

function automatic logic [15:0] crc16_ibm_step(input logic [15:0] crc, input logic [7:0] b);
  logic [15:0] c;
  c = crc;
  for (int k = 0; k < 8; k++) begin
    if (c[0] ^ b[k]) c = (c >> 1) ^ lcpd_pkg::CRC_POLY;
    else c = c >> 1;
  end
  return c;
endfunction

class deframer_scoreboard;
  typedef enum logic [2:0] {
    HDR_LEN_LO, HDR_LEN_HI, HDR_CRC_LO, HDR_CRC_HI, IN_PAYLOAD, HALTED
  } frame_stage_t;

  frame_stage_t stage;
  logic [15:0] max_len;
  logic [15:0] frame_len;
  logic [15:0] want_crc;
  logic [15:0] run_crc;
  logic [15:0] remaining;
  lcpd_pkg::out_t expected_results[$];
  int errors;

  function new();
    max_len = lcpd_pkg::MAX_LENGTH_RESET;
    errors = 0;
    clear_framing();
  endfunction

  function void clear_framing();
    stage = HDR_LEN_LO;
    frame_len = '0;
    want_crc = '0;
    run_crc = lcpd_pkg::CRC_INIT;
    remaining = '0;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  task report(input string what);
    if (errors < 30) $display("MISMATCH: %s", what);
    errors++;
  endtask

  function void note_beat(input lcpd_pkg::in_t beat);
    lcpd_pkg::out_t r;
    logic [7:0] b;
    b = beat.data_byte;
    if (beat.action) begin
      clear_framing();
      return;
    end
    case (stage)
      HDR_LEN_LO: begin
        frame_len = {8'h00, b};
        stage = HDR_LEN_HI;
      end
      HDR_LEN_HI: begin
        frame_len[15:8] = b;
        stage = HDR_CRC_LO;
      end
      HDR_CRC_LO: begin
        want_crc = {8'h00, b};
        stage = HDR_CRC_HI;
      end
      HDR_CRC_HI: begin
        want_crc[15:8] = b;
        run_crc = lcpd_pkg::CRC_INIT;
        if (frame_len > max_len) begin
          stage = HALTED;
          r = {1'b0, 8'h00, 1'b1, lcpd_pkg::ST_SIZE_ERR};
          expected_results.push_back(r);
        end else if (frame_len == 16'd0) begin
          if (want_crc != lcpd_pkg::CRC_INIT) begin
            stage = HALTED;
            r = {1'b0, 8'h00, 1'b1, lcpd_pkg::ST_CRC_ERR};
          end else begin
            stage = HDR_LEN_LO;
            r = {1'b0, 8'h00, 1'b1, lcpd_pkg::ST_OK};
          end
          expected_results.push_back(r);
        end else begin
          remaining = frame_len;
          stage = IN_PAYLOAD;
        end
      end
      IN_PAYLOAD: begin
        run_crc = crc16_ibm_step(run_crc, b);
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          if (run_crc != want_crc) begin
            stage = HALTED;
            r = {1'b1, b, 1'b1, lcpd_pkg::ST_CRC_ERR};
          end else begin
            stage = HDR_LEN_LO;
            r = {1'b1, b, 1'b1, lcpd_pkg::ST_OK};
          end
        end else begin
          r = {1'b1, b, 1'b0, lcpd_pkg::ST_OK};
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task check_beat(input lcpd_pkg::out_t got);
    lcpd_pkg::out_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_results.pop_front();
    if (got.has_byte !== want.has_byte)
      report($sformatf("has_byte %b, want %b", got.has_byte, want.has_byte));
    if (got.payload_byte !== want.payload_byte)
      report($sformatf("payload_byte %h, want %h", got.payload_byte, want.payload_byte));
    if (got.end_of_packet !== want.end_of_packet)
      report($sformatf("end_of_packet %b, want %b", got.end_of_packet, want.end_of_packet));
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic push;
  logic full;
  lcpd_pkg::in_t item;
  logic empty;
  logic pop;
  lcpd_pkg::out_t result;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  lcpd_pkg::in_t in_seen;
  lcpd_pkg::out_t out_seen;

  bit steady = 1'b0;
  bit stall_request = 1'b0;
  int beats_sent = 0;
  int cur_max = 2048;
  int cycles = 0;

  deframer_scoreboard sb = new();

  length_crc_packet_deframer_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result)
  );

  always #1 clk = ~clk;

  // handshakes are sampled mid-cycle, then acted on at the next rising edge
  always @(negedge clk) begin
    in_fire = push && !full && !rst;
    out_fire = pop && !empty && !rst;
    in_seen = item;
    out_seen = result;
  end

  always @(posedge clk) begin
    if (out_fire) sb.check_beat(out_seen);
    if (in_fire) sb.note_beat(in_seen);
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("length_crc_packet_deframer_top regression: fail");
      $finish;
    end
  end

  // receiver
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_request = 1'b0;
      end
      pop <= steady || ($urandom_range(99) >= 6);
    end
  end

  task automatic send_beat(input logic act, input logic [7:0] b);
    if (!steady && $urandom_range(99) < 6) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    item <= {act, b};
    @(posedge clk);
    while (!in_fire) @(posedge clk);
    beats_sent++;
  endtask

  // cut >= 0 stops after that many beats
  task automatic send_frame(input logic [15:0] len_field, input byte_q_t body,
                            input bit bad_crc, input int cut);
    logic [15:0] crc;
    byte_q_t wire_q;
    crc = lcpd_pkg::CRC_INIT;
    foreach (body[i]) crc = crc16_ibm_step(crc, body[i]);
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    wire_q = {len_field[7:0], len_field[15:8], crc[7:0], crc[15:8]};
    foreach (body[i]) wire_q.push_back(body[i]);
    foreach (wire_q[i])
      if (cut < 0 || i < cut) send_beat(1'b0, wire_q[i]);
  endtask

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(input int v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= 16'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.max_len = 16'(v);
    cur_max = v;
  endtask

  task automatic random_traffic(input int goal);
    int stop;
    int pick;
    int top;
    int short_top;
    int len;
    stop = beats_sent + goal;
    top = (cur_max < 40) ? cur_max : 40;
    short_top = (top < 12) ? top : 12;
    while (beats_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 70 || (pick >= 82 && pick < 90 && cur_max == 65535)) begin
        if ($urandom_range(99) < 15) len = top;
        else if ($urandom_range(99) < 12) len = $urandom_range(0, top);
        else len = $urandom_range(0, short_top);
        send_frame(16'(len), random_body(len), 1'b0, -1);
      end else if (pick < 82) begin
        len = $urandom_range(0, short_top);
        send_frame(16'(len), random_body(len), 1'b1, -1);
        repeat ($urandom_range(0, 3)) send_beat(1'b0, 8'($urandom));
        send_beat(1'b1, 8'($urandom));
      end else if (pick < 90) begin
        if ($urandom_range(1) == 1) len = cur_max + 1;
        else len = $urandom_range(cur_max + 1, 65535);
        send_frame(16'(len), random_body($urandom_range(0, 3)), 1'b0, -1);
        send_beat(1'b1, 8'($urandom));
      end else if (pick < 95) begin
        len = $urandom_range(0, top);
        send_frame(16'(len), random_body(len), 1'b0, $urandom_range(1, len + 3));
        send_beat(1'b1, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_beat($urandom_range(99) < 30, 8'($urandom));
        send_beat(1'b1, 8'($urandom));
      end
    end
  endtask

  initial begin
    int phase_max [6] = '{2048, 65535, 16, 0, 0, 7};
    byte_q_t body;
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    phase_max[4] = $urandom_range(1, 40);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty frames, good then bad CRC (halts, next byte dropped)
    body = {};
    send_frame(16'd0, body, 1'b0, -1);
    send_frame(16'd0, body, 1'b1, -1);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b1, 8'h00);
    body = {8'h00, 8'hFF};
    send_frame(16'd2, body, 1'b0, -1);
    body = {8'hA5};
    send_frame(16'd1, body, 1'b1, -1);
    send_beat(1'b1, 8'hFF);
    // largest length field, over the limit
    send_frame(16'hFFFF, body, 1'b0, -1);
    send_beat(1'b1, 8'h00);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        write_max_length(phase_max[p]);
      end
      steady = (p == 2);
      if (p == 1) begin
        stall_request = 1'b1;
        send_frame(16'd40, random_body(40), 1'b0, -1);
      end
      random_traffic(115);
    end
    steady = 1'b0;
    drain();
    repeat (6) @(posedge clk);

    if (sb.pending() != 0) sb.report("results missing at end of run");
    if (sb.errors == 0) $display("length_crc_packet_deframer_top regression: pass");
    else $display("length_crc_packet_deframer_top regression: fail");
    $finish;
  end
endmodule
